[src/umcv_pkg.sv]
package umcv_pkg;

  // Field widths of the stream payload and the register
  localparam int IdxW  = 12;
  localparam int ClsW  = 4;
  localparam int CfgW  = 5;
  localparam int VoteW = 9;

  // Parameter defaults
  localparam int DefMaxPoints  = 256;
  localparam int DefMaxClasses = 16;

  // Entries at or above this index count as no match
  localparam int DictEntries = 4096;

  localparam logic [VoteW-1:0] VoteLimit     = 9'd511;
  localparam logic [CfgW-1:0]  ClassCountRst = 5'd16;

  // One stored keypoint
  typedef struct packed {
    logic            matched;
    logic [IdxW-1:0] index;
    logic [ClsW-1:0] cls;
    logic            dup;
  } point_t;

  // Duplicate probe walking down the row of cells
  typedef struct packed {
    logic            valid;
    logic            matched;
    logic            hit;
    logic [IdxW-1:0] index;
  } probe_t;

  // Controls from the sequencer to the tally unit
  typedef struct packed {
    logic vote;
    logic scan;
    logic clear;
  } tally_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_UNLOAD,
    ST_SCAN
  } state_e;

endpackage

[src/unique_match_class_vote.sv]
// Unique-match class vote over the keypoints of one image.
//
// Input stream: one request per keypoint. tdata carries matched, entry_index and
// entry_class; tlast marks the final keypoint of the image. Keypoints load one
// per cycle into a row of cells, each cell holding one keypoint; up to
// MAX_POINTS are kept, later ones are dropped but their tlast still ends the
// image. As each keypoint loads, a probe walks down the row one cell a cycle
// and marks every earlier keypoint with the same dictionary index as a
// duplicate, and its own cell too.
// After the last request the block waits for the probes to finish, shifts the row
// out through the tally, then scans the L active classes (class_count capped at
// MAX_CLASSES), one a cycle, for the best count. The input stays closed (tready
// low) from the last request until the result is taken into the output register.
// Output stream: one request per image, best_class and best_votes in tdata.
// When the receiver stalls the result holds in the output register; the next
// image loads meanwhile but its result waits until the first one is taken.
// Reset empties the row, clears the tallies and sets class_count to 16. The user
// writes class_count via cfg_we_i / cfg_wdata_i while the block idles; not enforced.
module unique_match_class_vote import umcv_pkg::*; #(
  parameter int MAX_POINTS  = DefMaxPoints,
  parameter int MAX_CLASSES = DefMaxClasses
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,   // class_count
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,  // matched, entry_index, entry_class, zero pad
  input  logic            s_axis_tlast,  // last_point
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata   // best_class, best_votes, zero pad
);

  localparam int CntW = $clog2(MAX_POINTS + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  tmr_q, tmr_d;
  logic [CntW-1:0]  count_inc;
  logic [CfgW-1:0]  class_count_q;
  logic [CfgW-1:0]  limit;
  logic             accept;
  logic             store;
  logic             shift_en;
  logic             out_free;
  logic             out_load;
  logic             out_valid_q;
  logic [ClsW-1:0]  out_class_q;
  logic [VoteW-1:0] out_votes_q;
  logic             scan_done;
  logic [ClsW-1:0]  best_class;
  logic [VoteW-1:0] best_votes;
  tally_ctl_t       tally_ctl;
  point_t           in_pnt;
  point_t           pnt [MAX_POINTS];
  probe_t           prb [MAX_POINTS+1];

  // Register write; the user writes only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= ClassCountRst;
    end else if (cfg_we_i) begin
      class_count_q <= cfg_wdata_i;
    end
  end

  // Cap the class count at the tally depth
  assign limit = (32'(class_count_q) > MAX_CLASSES) ? CfgW'(MAX_CLASSES) : class_count_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign store  = accept && (count_q < CntW'(MAX_POINTS));

  // Unpack the request; an index beyond the dictionary counts as no match
  always_comb begin
    in_pnt.index   = s_axis_tdata[12:1];
    in_pnt.cls     = s_axis_tdata[16:13];
    in_pnt.matched = s_axis_tdata[0] && (32'(in_pnt.index) < DictEntries);
    in_pnt.dup     = 1'b0;
  end

  // Launch a probe for every stored keypoint; it enters cell 0 next cycle
  always_comb begin
    prb[0].valid   = store;
    prb[0].matched = in_pnt.matched;
    prb[0].hit     = 1'b0;
    prb[0].index   = in_pnt.index;
  end

  // Row of cells: written at the fill position, shifted toward cell 0 on unload
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    point_t nbr;
    if (k < MAX_POINTS - 1) begin : g_mid
      assign nbr = pnt[k+1];
    end else begin : g_end
      assign nbr = pnt[k];
    end
    umcv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (store && (count_q == CntW'(k))),
      .wr_pnt_i   (in_pnt),
      .shift_en_i (shift_en),
      .nbr_i      (nbr),
      .probe_i    (prb[k]),
      .probe_o    (prb[k+1]),
      .pnt_o      (pnt[k])
    );
  end

  // Tally fed from cell 0 while the row shifts out, then scanned for the best
  umcv_tally #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (tally_ctl),
    .vote_i       (pnt[0]),
    .limit_i      (limit),
    .done_o       (scan_done),
    .best_class_o (best_class),
    .best_votes_o (best_votes)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && s_axis_tlast) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tmr_q <= CntW'(1)) state_d = ST_UNLOAD;
      end
      ST_UNLOAD: begin
        if (count_q == '0) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done && out_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Sequencer outputs and counters
  assign count_inc = store ? count_q + CntW'(1) : count_q;

  always_comb begin
    s_axis_tready   = 1'b0;
    shift_en        = 1'b0;
    out_load        = 1'b0;
    count_d         = count_q;
    tmr_d           = tmr_q;
    tally_ctl       = '0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        count_d       = count_inc;
        // The drain timer is loaded with the stored keypoint count so the last probe can finish
        tmr_d         = count_inc;
      end
      ST_DRAIN: begin
        tmr_d = tmr_q - CntW'(1);
      end
      ST_UNLOAD: begin
        shift_en       = (count_q != '0);
        tally_ctl.vote = shift_en;
        if (shift_en) count_d = count_q - CntW'(1);
      end
      ST_SCAN: begin
        tally_ctl.scan  = 1'b1;
        out_load        = scan_done && out_free;
        tally_ctl.clear = out_load;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      tmr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tmr_q       <= tmr_d;
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_class_q <= best_class;
      out_votes_q <= best_votes;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_votes_q, out_class_q};

endmodule

[src/umcv_cell.sv]
module umcv_cell import umcv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  point_t wr_pnt_i,
  input  logic   shift_en_i,
  input  point_t nbr_i,
  input  probe_t probe_i,
  output probe_t probe_o,
  output point_t pnt_o
);

  point_t pnt_q;
  probe_t probe_q;
  logic   fresh_q;
  logic   hit_here;
  logic   own;

  // A fresh cell has not yet seen its own probe: that probe finishes here
  assign own      = probe_q.valid && fresh_q;
  assign hit_here = probe_q.valid && !fresh_q && probe_q.matched && pnt_q.matched &&
                    (probe_q.index == pnt_q.index);

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = probe_q.valid && !fresh_q;
    probe_o.hit   = probe_q.hit || hit_here;
  end

  assign pnt_o = pnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      fresh_q <= 1'b0;
    end else begin
      probe_q <= probe_i;
      if (wr_en_i) begin
        fresh_q <= 1'b1;
      end else if (own) begin
        fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pnt_q <= '{matched: wr_pnt_i.matched, index: wr_pnt_i.index,
                 cls: wr_pnt_i.cls, dup: 1'b0};
    end else if (shift_en_i) begin
      pnt_q <= nbr_i;
    end else if (own) begin
      pnt_q.dup <= pnt_q.dup || probe_q.hit;
    end else if (hit_here) begin
      pnt_q.dup <= 1'b1;
    end
  end

endmodule

[src/umcv_tally.sv]
module umcv_tally import umcv_pkg::*; #(
  parameter int MAX_CLASSES = DefMaxClasses
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tally_ctl_t       ctl_i,
  input  point_t           vote_i,
  input  logic [CfgW-1:0]  limit_i,
  output logic             done_o,
  output logic [ClsW-1:0]  best_class_o,
  output logic [VoteW-1:0] best_votes_o
);

  localparam int TIdxW = $clog2(MAX_CLASSES);

  logic [VoteW-1:0] tally_q [MAX_CLASSES];
  logic [CfgW-1:0]  scan_q;
  logic [CfgW-1:0]  best_class_q;
  logic [VoteW-1:0] best_votes_q;
  logic             vote_ok;
  logic             scan_ok;
  logic [TIdxW-1:0] vote_idx;
  logic [TIdxW-1:0] scan_idx;

  assign vote_idx = TIdxW'(vote_i.cls);
  assign scan_idx = TIdxW'(scan_q);
  assign vote_ok  = ctl_i.vote && vote_i.matched && !vote_i.dup &&
                    (CfgW'(vote_i.cls) < limit_i);
  assign scan_ok  = ctl_i.scan && (scan_q < limit_i);
  assign done_o   = (scan_q >= limit_i);

  assign best_class_o = ClsW'(best_class_q);
  assign best_votes_o = best_votes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) tally_q[i] <= '0;
      scan_q       <= '0;
      best_class_q <= '0;
      best_votes_q <= '0;
    end else if (ctl_i.clear) begin
      for (int i = 0; i < MAX_CLASSES; i++) tally_q[i] <= '0;
      scan_q       <= '0;
      best_class_q <= '0;
      best_votes_q <= '0;
    end else begin
      // Saturate the tally
      if (vote_ok && (tally_q[vote_idx] < VoteLimit)) begin
        tally_q[vote_idx] <= tally_q[vote_idx] + VoteW'(1);
      end
      // Strict compare keeps the lowest class on a tie
      if (scan_ok) begin
        if (tally_q[scan_idx] > best_votes_q) begin
          best_votes_q <= tally_q[scan_idx];
          best_class_q <= scan_q;
        end
        scan_q <= scan_q + CfgW'(1);
      end
    end
  end

endmodule

[src/umcv_chk.sv]
module umcv_chk import umcv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The vote runs after the last keypoint, so the input closes
  a_close_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last keypoint");

  // No votes means class 0
  a_no_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[12:4] == '0) |-> (m_axis_tdata[3:0] == '0))
    else $error("zero votes with nonzero class");

endmodule

bind unique_match_class_vote umcv_chk u_umcv_chk (.*);
